// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, idle while reset is held.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/rgbx_pkg.sv -----
`timescale 1ns / 1ps
package rgbx_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned DW     = 36;  // weighted distance width

  // luma weights squared, scaled by 10^6
  localparam logic [18:0] W_R = 19'd89401;
  localparam logic [18:0] W_G = 19'd344569;
  localparam logic [18:0] W_B = 19'd12996;

  localparam logic [7:0] CUBE_BASE = 8'd16;
  localparam logic [7:0] GRAY_BASE = 8'd232;
  localparam logic [9:0] THIRD_MUL = 10'd683;  // 683/2048 ~ 1/3

  typedef logic [2:0] level_lut_t [256];
  typedef logic [4:0] gstep_lut_t [256];
  typedef logic [7:0] gval_lut_t  [24];

  function automatic level_lut_t build_level_lut();
    level_lut_t t;
    for (int i = 0; i < 256; i++) t[i] = 3'((i + 25) / 51);
    return t;
  endfunction

  function automatic gstep_lut_t build_gstep_lut();
    gstep_lut_t t;
    for (int i = 0; i < 256; i++) begin
      if (i < 5) t[i] = 5'd0;
      else if (i > 250) t[i] = 5'd23;
      else t[i] = 5'(((i - 5) * 23) / 245);
    end
    return t;
  endfunction

  function automatic gval_lut_t build_gval_lut();
    gval_lut_t t;
    for (int i = 0; i < 24; i++) t[i] = 8'((i * 255) / 23);
    return t;
  endfunction

  localparam level_lut_t LEVEL_LUT = build_level_lut();
  localparam gstep_lut_t GSTEP_LUT = build_gstep_lut();
  localparam gval_lut_t  GVAL_LUT  = build_gval_lut();

  // classified word passed from front to back
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] lvl_r;
    logic [2:0] lvl_g;
    logic [2:0] lvl_b;
    logic       gray_ok;
    logic [4:0] gstep;
  } cls_t;

endpackage

// ----- hdl/rgbx_if.sv -----
`timescale 1ns / 1ps
interface rgbx_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbx_idx_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;
  modport source (output valid, color_index, input ready);
  modport sink   (input valid, color_index, output ready);
endinterface

// ----- hdl/rgb_to_xterm256_index_core.sv -----
`timescale 1ns / 1ps
// Maps one 8-bit RGB word to the nearest xterm-256 palette index (16..255)
// under a luma-weighted squared distance, trying the gray ramp when all
// channel differences are below gray_threshold (reset 16; 0 disables gray).
// Throughput is one word per clock while the output is not held. The front
// classifies in the accept cycle into a 4-entry queue, and the back runs a
// 4-stage pipeline (square, weight multiply, sum, compare) ending in the
// output register. The queue lets the input keep taking words while the
// output is held, until the queue is full.
module rgb_to_xterm256_index_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  rgbx_pix_if.sink   pix_i,
  rgbx_idx_if.source idx_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import rgbx_pkg::*;

  logic [7:0] gray_threshold_q;
  cls_t       cls, head;
  logic       head_valid, head_ready;

  // config register, written only while idle; the user must keep to this, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gray_threshold_q <= 8'd16;
    else if (cfg_we_i) gray_threshold_q <= cfg_wdata_i;
  end

  // front: level rounding, gray test, gray ramp step
  rgbx_front u_front (
    .red_i            (pix_i.red),
    .green_i          (pix_i.green),
    .blue_i           (pix_i.blue),
    .gray_threshold_i (gray_threshold_q),
    .cls_o            (cls)
  );

  rgbx_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (pix_i.valid),
    .push_ready_o (pix_i.ready),
    .push_data_i  (cls),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_data_o   (head)
  );

  // back: distances and final pick
  rgbx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (head_valid),
    .in_ready_o    (head_ready),
    .in_data_i     (head),
    .out_valid_o   (idx_o.valid),
    .out_ready_i   (idx_o.ready),
    .color_index_o (idx_o.color_index)
  );

endmodule

// ----- hdl/rgbx_front.sv -----
`timescale 1ns / 1ps
module rgbx_front (
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  input  logic [7:0]    gray_threshold_i,
  output rgbx_pkg::cls_t cls_o
);
  import rgbx_pkg::*;

  logic [7:0]  d_rg, d_gb, d_rb;
  logic [9:0]  sum;
  logic [19:0] prod;
  logic [7:0]  avg;

  always_comb begin
    d_rg = (red_i > green_i)  ? red_i - green_i  : green_i - red_i;
    d_gb = (green_i > blue_i) ? green_i - blue_i : blue_i - green_i;
    d_rb = (red_i > blue_i)   ? red_i - blue_i   : blue_i - red_i;
    sum  = 10'(red_i) + 10'(green_i) + 10'(blue_i);
    prod = 20'(sum) * 20'(THIRD_MUL);
    avg  = prod[18:11];  // floor(sum/3), exact for sum <= 765

    cls_o.red     = red_i;
    cls_o.green   = green_i;
    cls_o.blue    = blue_i;
    cls_o.lvl_r   = LEVEL_LUT[red_i];
    cls_o.lvl_g   = LEVEL_LUT[green_i];
    cls_o.lvl_b   = LEVEL_LUT[blue_i];
    cls_o.gray_ok = (d_rg < gray_threshold_i) && (d_gb < gray_threshold_i) &&
                    (d_rb < gray_threshold_i);
    cls_o.gstep   = GSTEP_LUT[avg];
  end

endmodule

// ----- hdl/rgbx_queue.sv -----
`timescale 1ns / 1ps
module rgbx_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  rgbx_pkg::cls_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output rgbx_pkg::cls_t pop_data_o
);
  import rgbx_pkg::*;

  cls_t             mem_q [QDEPTH];
  logic [QAW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QAW:0]     cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != (QAW+1)'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ----- hdl/rgbx_back.sv -----
`timescale 1ns / 1ps
module rgbx_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rgbx_pkg::cls_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     color_index_o
);
  import rgbx_pkg::*;

  // stage valids and stall chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  assign r4 = !v4_q | out_ready_i;
  assign r3 = !v3_q | r4;
  assign r2 = !v2_q | r3;
  assign r1 = !v1_q | r2;
  assign in_ready_o = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  // stage 1: per-axis differences squared
  logic [7:0] cv_r, cv_g, cv_b, gv;
  logic [7:0] cd_r, cd_g, cd_b, gd_r, gd_g, gd_b;
  logic [9:0]  csq_r_q, csq_g_q, csq_b_q;
  logic [15:0] gsq_r_q, gsq_g_q, gsq_b_q;
  logic [7:0]  cidx1_q, gidx1_q;
  logic        gok1_q;

  always_comb begin
    cv_r = 8'(in_data_i.lvl_r) * 8'd51;
    cv_g = 8'(in_data_i.lvl_g) * 8'd51;
    cv_b = 8'(in_data_i.lvl_b) * 8'd51;
    gv   = GVAL_LUT[in_data_i.gstep];
    cd_r = (in_data_i.red > cv_r)   ? in_data_i.red - cv_r   : cv_r - in_data_i.red;
    cd_g = (in_data_i.green > cv_g) ? in_data_i.green - cv_g : cv_g - in_data_i.green;
    cd_b = (in_data_i.blue > cv_b)  ? in_data_i.blue - cv_b  : cv_b - in_data_i.blue;
    gd_r = (in_data_i.red > gv)     ? in_data_i.red - gv     : gv - in_data_i.red;
    gd_g = (in_data_i.green > gv)   ? in_data_i.green - gv   : gv - in_data_i.green;
    gd_b = (in_data_i.blue > gv)    ? in_data_i.blue - gv    : gv - in_data_i.blue;
  end

  // the rounded cell is per axis strictly nearest, so it is the cube winner
  always_ff @(posedge clk_i) begin
    if (r1) begin
      csq_r_q <= 10'(cd_r[4:0]) * 10'(cd_r[4:0]);
      csq_g_q <= 10'(cd_g[4:0]) * 10'(cd_g[4:0]);
      csq_b_q <= 10'(cd_b[4:0]) * 10'(cd_b[4:0]);
      gsq_r_q <= 16'(gd_r) * 16'(gd_r);
      gsq_g_q <= 16'(gd_g) * 16'(gd_g);
      gsq_b_q <= 16'(gd_b) * 16'(gd_b);
      cidx1_q <= CUBE_BASE + 8'(in_data_i.lvl_r) * 8'd36 +
                 8'(in_data_i.lvl_g) * 8'd6 + 8'(in_data_i.lvl_b);
      gidx1_q <= GRAY_BASE + 8'(in_data_i.gstep);
      gok1_q  <= in_data_i.gray_ok;
    end
  end

  // stage 2: weighted products
  logic [DW-1:0] cp_r_q, cp_g_q, cp_b_q, gp_r_q, gp_g_q, gp_b_q;
  logic [7:0]    cidx2_q, gidx2_q;
  logic          gok2_q;

  always_ff @(posedge clk_i) begin
    if (r2) begin
      cp_r_q  <= DW'(W_R) * DW'(csq_r_q);
      cp_g_q  <= DW'(W_G) * DW'(csq_g_q);
      cp_b_q  <= DW'(W_B) * DW'(csq_b_q);
      gp_r_q  <= DW'(W_R) * DW'(gsq_r_q);
      gp_g_q  <= DW'(W_G) * DW'(gsq_g_q);
      gp_b_q  <= DW'(W_B) * DW'(gsq_b_q);
      cidx2_q <= cidx1_q;
      gidx2_q <= gidx1_q;
      gok2_q  <= gok1_q;
    end
  end

  // stage 3: sums
  logic [DW-1:0] cdist_q, gdist_q;
  logic [7:0]    cidx3_q, gidx3_q;
  logic          gok3_q;

  always_ff @(posedge clk_i) begin
    if (r3) begin
      cdist_q <= cp_r_q + cp_g_q + cp_b_q;
      gdist_q <= gp_r_q + gp_g_q + gp_b_q;
      cidx3_q <= cidx2_q;
      gidx3_q <= gidx2_q;
      gok3_q  <= gok2_q;
    end
  end

  // stage 4: pick, gray only if strictly closer
  logic [7:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (r4) idx_q <= (gok3_q && (gdist_q < cdist_q)) ? gidx3_q : cidx3_q;
  end

  assign out_valid_o   = v4_q;
  assign color_index_o = idx_q;

endmodule

// ----- hdl/rgbx_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgbx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] color_index_i
);

  // palette entries below 16 are never produced
  `ASSERT_CLKD(a_idx_range, clk_i, rst_ni, out_valid_i |-> (color_index_i >= 8'd16), "index below 16")

  // no word leaves while reset is held
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_i, "output valid in reset")

  // a held word keeps its index
  `ASSERT_CLKD(a_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(color_index_i)), "held word changed")

endmodule

bind rgb_to_xterm256_index_core rgbx_checker u_rgbx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (idx_o.valid),
  .out_ready_i   (idx_o.ready),
  .color_index_i (idx_o.color_index)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import rgbx_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;

  rgbx_pix_if pix_if ();
  rgbx_idx_if idx_if ();

  rgb_to_xterm256_index_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if.sink),
    .idx_o      (idx_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // pixels waiting to be sent, palette indices waiting to come back
  pixel_t     pixel_q[$];
  logic [7:0] index_q[$];
  logic [7:0] gray_thr = 8'd16;  // testbench copy of the register
  int         err_cnt = 0;
  int         cyc_cnt = 0;
  int         hold_cnt = 0;      // long receiver hold-off, counted down
  bit         rx_stall_en = 1'b0;
  bit         tx_gap_en = 1'b0;

  function automatic logic [35:0] luma_dist(int r, int g, int b, int rr, int gg, int bb);
    longint dr, dg, db;
    dr = r - rr;
    dg = g - gg;
    db = b - bb;
    return 36'(89401 * dr * dr + 344569 * dg * dg + 12996 * db * db);
  endfunction

  // nearest palette entry: cube cell plus neighbors, then the gray ramp
  function automatic logic [7:0] nearest_index(pixel_t p, logic [7:0] thr);
    int r, g, b, lr, lg, lb, nr, ng, nb, avg, gi, gv;
    logic [35:0] best, d;
    logic [7:0] idx;
    r = p.red; g = p.green; b = p.blue;
    lr = (r + 25) / 51; lg = (g + 25) / 51; lb = (b + 25) / 51;
    idx = 8'(16 + 36 * lr + 6 * lg + lb);
    best = luma_dist(r, g, b, 51 * lr, 51 * lg, 51 * lb);
    for (int i = -1; i <= 1; i++)
      for (int j = -1; j <= 1; j++)
        for (int k = -1; k <= 1; k++) begin
          nr = lr + i; ng = lg + j; nb = lb + k;
          if (nr < 0 || nr > 5 || ng < 0 || ng > 5 || nb < 0 || nb > 5) continue;
          d = luma_dist(r, g, b, 51 * nr, 51 * ng, 51 * nb);
          if (d < best) begin
            best = d;
            idx = 8'(16 + 36 * nr + 6 * ng + nb);
          end
        end
    // near-gray pixels also try one ramp entry; strict compare keeps cube on ties
    if ((r > g ? r - g : g - r) < thr && (g > b ? g - b : b - g) < thr &&
        (r > b ? r - b : b - r) < thr) begin
      avg = (r + g + b) / 3;
      if (avg < 5) gi = 232;
      else if (avg > 250) gi = 255;
      else gi = 232 + ((avg - 5) * 23) / 245;
      gv = (gi == 232) ? 0 : ((gi - 232) * 255) / 23;
      if (luma_dist(r, g, b, gv, gv, gv) < best) idx = 8'(gi);
    end
    return idx;
  endfunction

  // driver: bursts of words with random gaps
  int gap_cnt = 0;
  always @(posedge clk_i) begin
    if (pix_if.valid && pix_if.ready) begin
      index_q.push_back(nearest_index({pix_if.red, pix_if.green, pix_if.blue}, gray_thr));
      void'(pixel_q.pop_front());
    end
    if (!(pix_if.valid && !pix_if.ready)) begin
      // current word gone (or none offered): pick what comes next
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        pix_if.valid <= 1'b0;
      end else if (pixel_q.size() > (pix_if.valid && pix_if.ready ? 0 : 0)) begin
        pix_if.valid <= 1'b1;
        {pix_if.red, pix_if.green, pix_if.blue} <= pixel_q[0];
        if (tx_gap_en && $urandom_range(0, 7) == 0) gap_cnt <= $urandom_range(1, 6);
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // monitor: receiver stall pattern, compare against oldest expected index
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (idx_if.valid && idx_if.ready) begin
      if (index_q.size() == 0) begin
        $error("unexpected word: color_index actual %0d", idx_if.color_index);
        err_cnt++;
      end else begin
        if (idx_if.color_index !== index_q[0]) begin
          $error("color_index expected %0d actual %0d", index_q[0], idx_if.color_index);
          err_cnt++;
        end
        void'(index_q.pop_front());
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      idx_if.ready <= 1'b0;
    end else begin
      idx_if.ready <= rx_stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cyc_cnt > 400000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic drain();
    wait (pixel_q.size() == 0);
    @(posedge clk_i);
    wait (index_q.size() == 0 && !pix_if.valid);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    gray_thr = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic pixel_t rand_pixel();
    int base, spread;
    pixel_t p;
    // about half near-gray pixels so the ramp path gets exercised
    if ($urandom_range(0, 1)) begin
      base = $urandom_range(0, 255);
      spread = $urandom_range(0, 40);
      p.red = 8'(base);
      p.green = 8'($urandom_range(base > spread ? base - spread : 0,
                                  base + spread > 255 ? 255 : base + spread));
      p.blue = 8'($urandom_range(base > spread ? base - spread : 0,
                                 base + spread > 255 ? 255 : base + spread));
    end else begin
      p = pixel_t'($urandom);
    end
    return p;
  endfunction

  initial begin
    logic [7:0] thr_set[5];
    thr_set = '{8'd0, 8'd1, 8'd255, 8'd40, 8'd16};
    pix_if.valid = 1'b0;
    pix_if.red = 8'd0; pix_if.green = 8'd0; pix_if.blue = 8'd0;
    idx_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, gray-ish, level boundaries, reset threshold
    pixel_q.push_back({8'd0, 8'd0, 8'd0});
    pixel_q.push_back({8'd255, 8'd255, 8'd255});
    pixel_q.push_back({8'd255, 8'd0, 8'd0});
    pixel_q.push_back({8'd0, 8'd255, 8'd0});
    pixel_q.push_back({8'd0, 8'd0, 8'd255});
    pixel_q.push_back({8'd4, 8'd4, 8'd4});
    pixel_q.push_back({8'd5, 8'd5, 8'd5});
    pixel_q.push_back({8'd250, 8'd250, 8'd250});
    pixel_q.push_back({8'd251, 8'd251, 8'd251});
    pixel_q.push_back({8'd128, 8'd128, 8'd128});
    pixel_q.push_back({8'd25, 8'd26, 8'd76});
    pixel_q.push_back({8'd100, 8'd110, 8'd115});
    pixel_q.push_back({8'd8, 8'd23, 8'd15});
    pixel_q.push_back({8'd170, 8'd85, 8'd170});
    pixel_q.push_back({8'd238, 8'd238, 8'd238});
    pixel_q.push_back({8'd170, 8'd170, 8'd85});
    pixel_q.push_back({8'd127, 8'd128, 8'd129});
    pixel_q.push_back({8'd60, 8'd60, 8'd60});
    drain();
    // threshold sweep; long receiver hold-off in phase 1 while the sender offers
    rx_stall_en = 1'b1;
    tx_gap_en = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      set_threshold(thr_set[ph]);
      if (ph == 1) hold_cnt = 60;
      for (int n = 0; n < 210; n++) pixel_q.push_back(rand_pixel());
      if (ph == 3) begin
        rx_stall_en = 1'b0;
        tx_gap_en = 1'b0;
      end
      drain();
      rx_stall_en = 1'b1;
      tx_gap_en = 1'b1;
    end
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
